// ----- rtl/cbhp_pkg.sv -----
// Package for the cipher blob header parser.
// Field widths, byte-role and error codes. No dependencies.
`default_nettype none

package cbhp_pkg;

  localparam int unsigned DataW    = 8;
  localparam int unsigned RoleW    = 3;
  localparam int unsigned ErrW     = 2;
  localparam int unsigned SizeW    = 32;
  localparam int unsigned HdrSizeW = 9;
  localparam int unsigned VerW     = 4;

  localparam logic [VerW-1:0] VersionReset = 4'd1;

  typedef logic [DataW-1:0] data_t;

  typedef enum logic [RoleW-1:0] {
    ROLE_FORMAT  = 3'd0,
    ROLE_IV_LEN  = 3'd1,
    ROLE_IV      = 3'd2,
    ROLE_LEN     = 3'd3,
    ROLE_AFTER   = 3'd4,
    ROLE_DISCARD = 3'd5
  } role_t;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE    = 2'd0,
    ERR_VERSION = 2'd1,
    ERR_WIDTH   = 2'd2,
    ERR_TRUNC   = 2'd3
  } err_t;

endpackage

`default_nettype wire

// ----- rtl/cbhp_if.sv -----
// Stream interfaces of the cipher blob header parser: byte input and result output.
// Depends on cbhp_pkg.
`default_nettype none

interface cbhp_in_if;
  logic          valid;
  logic          ready;
  cbhp_pkg::data_t data_byte;
  logic          start_of_blob;
  logic          end_of_buffer;

  modport source (output valid, data_byte, start_of_blob, end_of_buffer, input ready);
  modport sink   (input valid, data_byte, start_of_blob, end_of_buffer, output ready);
endinterface

interface cbhp_out_if;
  logic                             valid;
  logic                             ready;
  cbhp_pkg::role_t                  byte_role;
  cbhp_pkg::data_t                  iv_byte;
  cbhp_pkg::data_t                  iv_length;
  logic                             header_done;
  logic [cbhp_pkg::SizeW-1:0]       ciphertext_size;
  logic [cbhp_pkg::HdrSizeW-1:0]    header_size;
  cbhp_pkg::err_t                   error_code;

  modport source (output valid, byte_role, iv_byte, iv_length, header_done,
                  ciphertext_size, header_size, error_code, input ready);
  modport sink   (input valid, byte_role, iv_byte, iv_length, header_done,
                  ciphertext_size, header_size, error_code, output ready);
endinterface

`default_nettype wire

// ----- rtl/cipher_blob_header_parser.sv -----
// Cipher blob header parser: tags each blob byte with its role, passes out IV
// bytes, decodes the length field. Depends on cbhp_pkg and cbhp_if.
//
// Usage:
//   bytes_in carries one blob byte per transaction with start_of_blob and
//   end_of_buffer marks. results_out carries one result per input byte.
//   cfg_write_en/cfg_write_data load expected_version (reset value 1); write
//   only while no transaction is in flight.
//   Latency: the result of a byte is valid the cycle after it is accepted.
//   Throughput: one byte per cycle while results_out does not stall; the parse
//   state updates in the accept cycle and the result sits in a single output register.
//   Stall: while a result waits and results_out.ready is low, bytes_in.ready
//   drops; when the result is taken, a new byte is accepted in the same cycle.
//   Reset: parser state returns to the format byte with no error latched,
//   the output register empties and expected_version returns to 1.
//   A latched error holds, and later bytes are tagged discarded, until the
//   next start_of_blob.
`default_nettype none

module cipher_blob_header_parser (
  input  wire logic                     clk,
  input  wire logic                     rst,
  cbhp_in_if.sink                       bytes_in,
  cbhp_out_if.source                    results_out,
  input  wire logic                     cfg_write_en,
  input  wire logic [cbhp_pkg::VerW-1:0] cfg_write_data
);

  typedef enum logic [2:0] {
    PH_FORMAT = 3'd0,
    PH_IVLEN  = 3'd1,
    PH_IV     = 3'd2,
    PH_LEN    = 3'd3,
    PH_AFTER  = 3'd4,
    PH_ERROR  = 3'd5
  } phase_t;

  logic [cbhp_pkg::VerW-1:0]  expected_version;
  phase_t                     parse_phase, parse_phase_next;
  logic [7:0]                 bytes_left, bytes_left_next;
  logic [2:0]                 length_width, length_width_next;
  logic [31:0]                length_accumulator, length_accumulator_next;
  logic [7:0]                 declared_iv_length, declared_iv_length_next;
  cbhp_pkg::err_t             latched_error, latched_error_next;

  cbhp_pkg::role_t            role;
  cbhp_pkg::data_t            ivb;
  logic                       done;
  logic [31:0]                ctsize;
  logic [8:0]                 hsize;

  phase_t                     ph;
  logic [7:0]                 bl, bl_dec;
  logic [2:0]                 lw;
  logic [31:0]                acc;
  logic [7:0]                 ivl;
  cbhp_pkg::err_t             err;
  logic [3:0]                 w_nib;
  cbhp_pkg::data_t            b;
  logic                       accept;

  assign b      = bytes_in.data_byte;
  assign w_nib  = b[7:4];
  assign bytes_in.ready = !results_out.valid || results_out.ready;
  assign accept = bytes_in.valid && bytes_in.ready;

  always_comb begin
    if (bytes_in.start_of_blob) begin
      ph  = PH_FORMAT;
      bl  = '0;
      lw  = '0;
      acc = '0;
      ivl = '0;
      err = cbhp_pkg::ERR_NONE;
    end else begin
      ph  = parse_phase;
      bl  = bytes_left;
      lw  = length_width;
      acc = length_accumulator;
      ivl = declared_iv_length;
      err = latched_error;
    end
    bl_dec = bl - 8'd1;

    parse_phase_next        = ph;
    bytes_left_next         = bl;
    length_width_next       = lw;
    length_accumulator_next = acc;
    declared_iv_length_next = ivl;
    latched_error_next      = err;
    ivb    = '0;
    done   = 1'b0;
    ctsize = '0;
    hsize  = '0;

    case (ph)
      PH_FORMAT: begin
        role = cbhp_pkg::ROLE_FORMAT;
        if (b[3:0] != expected_version) begin
          latched_error_next = cbhp_pkg::ERR_VERSION;
          parse_phase_next   = PH_ERROR;
        end else if (w_nib != 4'd1 && w_nib != 4'd2 && w_nib != 4'd4) begin
          latched_error_next = cbhp_pkg::ERR_WIDTH;
          parse_phase_next   = PH_ERROR;
        end else begin
          length_width_next = w_nib[2:0];
          parse_phase_next  = PH_IVLEN;
        end
      end
      PH_IVLEN: begin
        role = cbhp_pkg::ROLE_IV_LEN;
        declared_iv_length_next = b;
        length_accumulator_next = '0;
        if (b == 8'd0) begin
          bytes_left_next  = {5'd0, lw};
          parse_phase_next = PH_LEN;
        end else begin
          bytes_left_next  = b;
          parse_phase_next = PH_IV;
        end
      end
      PH_IV: begin
        role = cbhp_pkg::ROLE_IV;
        ivb  = b;
        bytes_left_next = bl_dec;
        if (bl_dec == 8'd0) begin
          bytes_left_next  = {5'd0, lw};
          parse_phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        role = cbhp_pkg::ROLE_LEN;
        length_accumulator_next = {acc[23:0], b};
        bytes_left_next = bl_dec;
        if (bl_dec == 8'd0) begin
          done   = 1'b1;
          ctsize = {acc[23:0], b};
          hsize  = 9'd2 + {1'b0, ivl} + {6'd0, lw};
          parse_phase_next = PH_AFTER;
        end
      end
      PH_AFTER: role = cbhp_pkg::ROLE_AFTER;
      default:  role = cbhp_pkg::ROLE_DISCARD;
    endcase

    if (bytes_in.end_of_buffer && parse_phase_next != PH_AFTER
        && parse_phase_next != PH_ERROR) begin
      latched_error_next = cbhp_pkg::ERR_TRUNC;
      parse_phase_next   = PH_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version   <= cbhp_pkg::VersionReset;
      parse_phase        <= PH_FORMAT;
      bytes_left         <= '0;
      length_width       <= '0;
      length_accumulator <= '0;
      declared_iv_length <= '0;
      latched_error      <= cbhp_pkg::ERR_NONE;
      results_out.valid  <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        expected_version <= cfg_write_data;
      end
      if (accept) begin
        parse_phase        <= parse_phase_next;
        bytes_left         <= bytes_left_next;
        length_width       <= length_width_next;
        length_accumulator <= length_accumulator_next;
        declared_iv_length <= declared_iv_length_next;
        latched_error      <= latched_error_next;
        results_out.valid  <= 1'b1;
      end else if (results_out.ready) begin
        results_out.valid  <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      results_out.byte_role       <= role;
      results_out.iv_byte         <= ivb;
      results_out.iv_length       <= declared_iv_length_next;
      results_out.header_done     <= done;
      results_out.ciphertext_size <= ctsize;
      results_out.header_size     <= hsize;
      results_out.error_code      <= latched_error_next;
    end
  end

endmodule

`default_nettype wire
